// ----- hdl/qtubc_pkg.sv -----
// Shared types and constants for the quadtree uniform block counter.
// No dependencies; imported by every module of the block.
package qtubc_pkg;

   localparam int SIDE_LOG2_MAX = 7;                  // largest supported side is 128
   localparam int SIDE_W        = 3;                  // width of the side_log2 register
   localparam int ADDR_W        = 2 * SIDE_LOG2_MAX;  // raster and Morton index width
   localparam int CNT_W         = 15;                 // leaf counter width
   localparam int LEVELS        = SIDE_LOG2_MAX;      // tree levels above single pixels

   localparam logic [SIDE_W-1:0] SIDE_LOG2_RESET = 3'd7;

   // One step of the Morton-order scan, aligned with the pixel RAM read data.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
   } walk_beat_type;

endpackage

// ----- hdl/qtubc_pixel_ram.sv -----
// Pixel store: 1-bit synchronous RAM, one write and one registered read port.
// Depends on qtubc_pkg for the address width.
module qtubc_pixel_ram
   import qtubc_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic pixel_mem_ff [2**ADDR_W];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pixel_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/qtubc_level_tree.sv -----
// Bottom-up quadtree evaluation over a Morton-order pixel stream.
// Keeps one partial node per level and the pixel / uniform-node tallies.
// Depends on qtubc_pkg.
module qtubc_level_tree
   import qtubc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  walk_beat_type    beat,
   input  logic             pixel,
   output logic [CNT_W-1:0] zero_leaves,
   output logic [CNT_W-1:0] one_leaves
);

   logic [LEVELS:1] acc_uni_ff, acc_uni_in;
   logic [LEVELS:1] acc_val_ff, acc_val_in;
   logic [CNT_W-1:0] pix0_ff, pix0_in, pix1_ff, pix1_in;
   logic [CNT_W-1:0] uni0_ff, uni0_in, uni1_ff, uni1_in;

   logic [LEVELS:0] ch_uni, ch_val, done;
   logic [1:0]      quad;
   logic [2:0]      uni0_inc, uni1_inc;

   // Walk up the levels: a node closes when its fourth child closes.
   always_comb begin
      ch_uni     = '0;
      ch_val     = '0;
      done       = '0;
      quad       = 2'd0;
      uni0_inc   = 3'd0;
      uni1_inc   = 3'd0;
      acc_uni_in = acc_uni_ff;
      acc_val_in = acc_val_ff;
      ch_uni[0]  = 1'b1;
      ch_val[0]  = pixel;
      done[0]    = beat.valid;
      for (int l = 1; l <= LEVELS; l++) begin
         quad = beat.index[2*l-1 -: 2];
         if (quad == 2'd0) begin
            ch_uni[l] = ch_uni[l-1];
            ch_val[l] = ch_val[l-1];
         end else begin
            ch_uni[l] = acc_uni_ff[l] & ch_uni[l-1] & (acc_val_ff[l] == ch_val[l-1]);
            ch_val[l] = acc_val_ff[l];
         end
         if (done[l-1]) begin
            acc_uni_in[l] = ch_uni[l];
            acc_val_in[l] = ch_val[l];
         end
         done[l] = done[l-1] & (quad == 2'd3);
         if (done[l] && ch_uni[l]) begin
            if (ch_val[l]) begin
               uni1_inc = uni1_inc + 3'd1;
            end else begin
               uni0_inc = uni0_inc + 3'd1;
            end
         end
      end
   end

   always_comb begin
      pix0_in = pix0_ff;
      pix1_in = pix1_ff;
      uni0_in = uni0_ff;
      uni1_in = uni1_ff;
      if (beat.valid) begin
         if (beat.index == '0) begin
            pix0_in = {{(CNT_W-1){1'b0}}, ~pixel};
            pix1_in = {{(CNT_W-1){1'b0}}, pixel};
            uni0_in = {{(CNT_W-3){1'b0}}, uni0_inc};
            uni1_in = {{(CNT_W-3){1'b0}}, uni1_inc};
         end else begin
            pix0_in = pix0_ff + {{(CNT_W-1){1'b0}}, ~pixel};
            pix1_in = pix1_ff + {{(CNT_W-1){1'b0}}, pixel};
            uni0_in = uni0_ff + {{(CNT_W-3){1'b0}}, uni0_inc};
            uni1_in = uni1_ff + {{(CNT_W-3){1'b0}}, uni1_inc};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_uni_ff <= '0;
         acc_val_ff <= '0;
         pix0_ff    <= '0;
         pix1_ff    <= '0;
         uni0_ff    <= '0;
         uni1_ff    <= '0;
      end else begin
         acc_uni_ff <= acc_uni_in;
         acc_val_ff <= acc_val_in;
         pix0_ff    <= pix0_in;
         pix1_ff    <= pix1_in;
         uni0_ff    <= uni0_in;
         uni1_ff    <= uni1_in;
      end
   end

   // Every uniform node above pixel level merges four uniform children into one,
   // so leaves = pixels of that value - 3 * uniform nodes of that value.
   assign zero_leaves = pix0_ff - (uni0_ff + {uni0_ff[CNT_W-2:0], 1'b0});
   assign one_leaves  = pix1_ff - (uni1_ff + {uni1_ff[CNT_W-2:0], 1'b0});

endmodule

// ----- hdl/quadtree_uniform_block_count.sv -----
// Quadtree uniform block counter, top level.
// Depends on qtubc_pkg, qtubc_pixel_ram and qtubc_level_tree.
//
// Usage:
//  - csr_wr_en / csr_wr_data set side_log2 (side = 2^side_log2, up to 128).
//    Write it only while the block is idle. Reset value is 7.
//  - req_* carries one pixel per transaction in raster order; req_last marks
//    the final pixel. Pixels are taken one per cycle while loading.
//  - After the last pixel the block scans the stored image in Morton order,
//    one pixel per cycle from the pixel RAM read port, and folds the quadtree
//    bottom-up. req_ready stays low from then until the result is registered.
//  - The result (counts of uniform 0 and 1 leaves) goes to an output register
//    on the rsp_* channel. Loading of the next image proceeds while it waits;
//    if the next scan finishes first it holds until rsp_ready takes the result.
//  - Synchronous reset clears the load position, the state machine and the
//    output valid; pixel RAM contents are not cleared.
module quadtree_uniform_block_count
   import qtubc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_pixel,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CNT_W-1:0]  rsp_zero_leaf_count,
   output logic [CNT_W-1:0]  rsp_one_leaf_count,
   input  logic              csr_wr_en,
   input  logic [SIDE_W-1:0] csr_wr_data
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SIDE_W-1:0] side_log2_ff, side_log2_in;
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic [ADDR_W-1:0] walk_idx_ff, walk_idx_in;
   walk_beat_type     beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_zero_ff, rsp_zero_in;
   logic [CNT_W-1:0]  rsp_one_ff, rsp_one_in;

   logic [ADDR_W-1:0] area_mask;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [SIDE_LOG2_MAX-1:0] walk_row, walk_col;
   logic              req_fire;
   logic              rd_en;
   logic              rd_pixel;
   logic [CNT_W-1:0]  zero_leaves, one_leaves;

   assign area_mask = (ADDR_W'(1) << {side_log2_ff, 1'b0}) - ADDR_W'(1);
   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid & req_ready;
   assign wr_addr   = load_pos_ff & area_mask;
   assign rd_en     = (state_ff == ST_WALK);

   // Morton index: even bits are the column, odd bits the row.
   always_comb begin
      for (int k = 0; k < SIDE_LOG2_MAX; k++) begin
         walk_col[k] = walk_idx_ff[2*k];
         walk_row[k] = walk_idx_ff[2*k+1];
      end
   end

   assign rd_addr = ({{(ADDR_W-SIDE_LOG2_MAX){1'b0}}, walk_row} << side_log2_ff)
                  | {{(ADDR_W-SIDE_LOG2_MAX){1'b0}}, walk_col};

   always_comb begin
      state_in     = state_ff;
      side_log2_in = side_log2_ff;
      load_pos_in  = load_pos_ff;
      walk_idx_in  = walk_idx_ff;
      beat_in      = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_zero_in  = rsp_zero_ff;
      rsp_one_in   = rsp_one_ff;
      if (csr_wr_en) begin
         side_log2_in = csr_wr_data;
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (req_last) begin
                  load_pos_in = '0;
                  walk_idx_in = '0;
                  state_in    = ST_WALK;
               end else begin
                  load_pos_in = (wr_addr + ADDR_W'(1)) & area_mask;
               end
            end
         end
         ST_WALK: begin
            beat_in.valid = 1'b1;
            beat_in.index = walk_idx_ff;
            walk_idx_in   = walk_idx_ff + ADDR_W'(1);
            if (walk_idx_ff == area_mask) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_leaves;
               rsp_one_in   = one_leaves;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         side_log2_ff <= SIDE_LOG2_RESET;
         load_pos_ff  <= '0;
         walk_idx_ff  <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_log2_ff <= side_log2_in;
         load_pos_ff  <= load_pos_in;
         walk_idx_ff  <= walk_idx_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_zero_ff <= rsp_zero_in;
      rsp_one_ff  <= rsp_one_in;
   end

   qtubc_pixel_ram u_pixel_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_pixel)
   );

   qtubc_level_tree u_level_tree (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat_ff),
      .pixel       (rd_pixel),
      .zero_leaves (zero_leaves),
      .one_leaves  (one_leaves)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_zero_leaf_count = rsp_zero_ff;
   assign rsp_one_leaf_count  = rsp_one_ff;

endmodule
